// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL modules, included by rsdz_skid.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define RSDZ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal holds in the cycle after the condition.
`define RSDZ_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== sv/rsdz_pkg.sv =====
package rsdz_pkg;

  // Default axis width and fixed field widths
  localparam int AXIS_BITS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int DZ_W          = 16;
  // Fraction bits of the vector length
  localparam int FRAC_W        = 16;

  localparam logic [DZ_W-1:0] DZ_RESET = 16'd9830;
  // One in Q1.16
  localparam logic [DZ_W:0]   DZ_ONE   = {1'b1, {DZ_W{1'b0}}};

  // Sign-extended axis samples carried along the pipeline
  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } axes_t;

  // Side information that travels through the divider
  typedef struct packed {
    axes_t axes;
    logic  dz_hit;
    logic  zero;
    logic  clamp;
  } div_side_t;

  // One finished result
  typedef struct packed {
    logic [FIELD_W-1:0] out_x;
    logic [FIELD_W-1:0] out_y;
    logic               dz_hit;
  } res_t;

  // Stage control handed to the pipelined units
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// ===== sv/rsdz_sqrt.sv =====
module rsdz_sqrt import rsdz_pkg::*; #(
  parameter int AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pipe_ctl_t                     ctl_i,
  input  logic [2*AXIS_BITS-1:0]        sum_i,
  input  axes_t                         axes_i,
  output logic                          valid_o,
  output logic [AXIS_BITS+FRAC_W-1:0]   root_o,
  output axes_t                         axes_o
);

  localparam int RB   = AXIS_BITS + FRAC_W;
  localparam int SW   = 2 * AXIS_BITS;
  localparam int REMW = RB + 2;

  logic [RB-1:0]   v_q;
  logic [REMW-1:0] rem_q  [RB];
  logic [RB-1:0]   root_q [RB];
  logic [SW-1:0]   sum_q  [RB];
  axes_t           axes_q [RB];
  logic [REMW-1:0] rem_d  [RB];
  logic [RB-1:0]   root_d [RB];

  // One root bit per stage, radicand is sum * 2^(2*FRAC_W)
  for (genvar k = 0; k < RB; k++) begin : g_step
    logic [REMW-1:0] rem_in;
    logic [RB-1:0]   root_in;
    logic [SW-1:0]   sum_in;
    logic [1:0]      pair;
    logic [REMW-1:0] remsh;
    logic [REMW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign sum_in  = sum_i;
    end else begin : g_tail
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sum_in  = sum_q[k-1];
    end

    // Low radicand pairs are the zero fraction bits
    if (k < AXIS_BITS) begin : g_sum_pair
      assign pair = sum_in[2*(AXIS_BITS-1-k) +: 2];
    end else begin : g_zero_pair
      assign pair = 2'b00;
    end

    assign remsh     = {rem_in[REMW-3:0], pair};
    assign trial     = {root_in, 2'b01};
    assign ge        = (remsh >= trial);
    assign rem_d[k]  = ge ? (remsh - trial) : remsh;
    assign root_d[k] = {root_in[RB-2:0], ge};
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[RB-2:0], ctl_i.valid};
    end
  end

  // Advance stage payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      sum_q[0]  <= sum_i;
      axes_q[0] <= axes_i;
      for (int k = 0; k < RB; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      for (int k = 1; k < RB; k++) begin
        sum_q[k]  <= sum_q[k-1];
        axes_q[k] <= axes_q[k-1];
      end
    end
  end

  assign valid_o = v_q[RB-1];
  assign root_o  = root_q[RB-1];
  assign axes_o  = axes_q[RB-1];

endmodule

// ===== sv/rsdz_div.sv =====
module rsdz_div import rsdz_pkg::*; #(
  parameter int AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  pipe_ctl_t                                ctl_i,
  input  logic [AXIS_BITS+FRAC_W+DZ_W+2:0]         p0x_i,
  input  logic [AXIS_BITS+FRAC_W+DZ_W+2:0]         p0y_i,
  input  logic [AXIS_BITS-1:0]                     lowx_i,
  input  logic [AXIS_BITS-1:0]                     lowy_i,
  input  logic [AXIS_BITS+FRAC_W+DZ_W+1:0]         div_i,
  input  div_side_t                                side_i,
  output logic                                     valid_o,
  output logic [AXIS_BITS-1:0]                     qx_o,
  output logic [AXIS_BITS-1:0]                     qy_o,
  output div_side_t                                side_o
);

  localparam int QB = AXIS_BITS;
  localparam int DV = AXIS_BITS + FRAC_W + DZ_W + 2;
  localparam int PW = DV + 1;

  logic [QB-1:0] v_q;
  logic [PW-1:0] px_q   [QB];
  logic [PW-1:0] py_q   [QB];
  logic [QB-1:0] qx_q   [QB];
  logic [QB-1:0] qy_q   [QB];
  logic [QB-1:0] lx_q   [QB];
  logic [QB-1:0] ly_q   [QB];
  logic [DV-1:0] dv_q   [QB];
  div_side_t     side_q [QB];
  logic [PW-1:0] px_d   [QB];
  logic [PW-1:0] py_d   [QB];
  logic [QB-1:0] qx_d   [QB];
  logic [QB-1:0] qy_d   [QB];

  // One quotient bit per stage on both axes, shared divisor
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [PW-1:0] px_in;
    logic [PW-1:0] py_in;
    logic [QB-1:0] qx_in;
    logic [QB-1:0] qy_in;
    logic [QB-1:0] lx_in;
    logic [QB-1:0] ly_in;
    logic [PW-1:0] dd;
    logic [PW-1:0] px_sh;
    logic [PW-1:0] py_sh;
    logic          gex;
    logic          gey;

    if (k == 0) begin : g_head
      assign px_in = p0x_i;
      assign py_in = p0y_i;
      assign qx_in = '0;
      assign qy_in = '0;
      assign lx_in = lowx_i;
      assign ly_in = lowy_i;
      assign dd    = PW'(div_i);
    end else begin : g_tail
      assign px_in = px_q[k-1];
      assign py_in = py_q[k-1];
      assign qx_in = qx_q[k-1];
      assign qy_in = qy_q[k-1];
      assign lx_in = lx_q[k-1];
      assign ly_in = ly_q[k-1];
      assign dd    = PW'(dv_q[k-1]);
    end

    assign px_sh   = {px_in[PW-2:0], lx_in[QB-1-k]};
    assign py_sh   = {py_in[PW-2:0], ly_in[QB-1-k]};
    assign gex     = (px_sh >= dd);
    assign gey     = (py_sh >= dd);
    assign px_d[k] = gex ? (px_sh - dd) : px_sh;
    assign py_d[k] = gey ? (py_sh - dd) : py_sh;
    assign qx_d[k] = {qx_in[QB-2:0], gex};
    assign qy_d[k] = {qy_in[QB-2:0], gey};
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[QB-2:0], ctl_i.valid};
    end
  end

  // Advance stage payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      lx_q[0]   <= lowx_i;
      ly_q[0]   <= lowy_i;
      dv_q[0]   <= div_i;
      side_q[0] <= side_i;
      for (int k = 0; k < QB; k++) begin
        px_q[k] <= px_d[k];
        py_q[k] <= py_d[k];
        qx_q[k] <= qx_d[k];
        qy_q[k] <= qy_d[k];
      end
      for (int k = 1; k < QB; k++) begin
        lx_q[k]   <= lx_q[k-1];
        ly_q[k]   <= ly_q[k-1];
        dv_q[k]   <= dv_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign qx_o    = qx_q[QB-1];
  assign qy_o    = qy_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

// ===== sv/rsdz_skid.sv =====
`include "assert_macros.svh"

module rsdz_skid import rsdz_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  res_t in_data_i,
  output logic en_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_v_q;
  logic skid_v_q;
  res_t out_q;
  res_t skid_q;
  logic take;

  assign take = out_v_q & out_ready_i;
  // Pipeline moves while the spare slot is empty
  assign en_o = ~skid_v_q;

  // Track output and spare occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en_o && in_valid_i) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Load output or spare, refill output from spare
  always_ff @(posedge clk_i) begin
    if (en_o && in_valid_i) begin
      if (!out_v_q || take) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end else if (take && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `RSDZ_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q, "spare full, output empty")
  `RSDZ_ASSERT(a_skid_catch, clk_i, rst_ni, (in_valid_i && en_o && out_v_q && !out_ready_i) |=> skid_v_q, "request lost at stalled output")
  `RSDZ_HOLD(a_skid_hold, clk_i, rst_ni, skid_v_q && !take, skid_q, "spare changed while held")
  `RSDZ_ASSERT(a_inside_zero, clk_i, rst_ni, (out_v_q && out_q.dz_hit) |-> (out_q.out_x == '0 && out_q.out_y == '0), "dead zone result not zero")

endmodule

// ===== sv/radial_stick_dead_zone_core.sv =====
// Throughput: one sample per cycle; a waiting result plus one in the spare slot stall the input.
// Most latency lies in the square root (AXIS_BITS+16 stages, one root bit each) and the divider
// (AXIS_BITS stages, one quotient bit each, both axes side by side).
// Reset (rst_ni low, asynchronous) clears all valid bits and loads dead_zone with 9830;
// the block takes samples in the first cycle after reset.
module radial_stick_dead_zone_core import rsdz_pkg::*; #(
  parameter int AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [2*FIELD_W-1:0] s_axis_tdata_i,   // raw_x [15:0], raw_y [31:16]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [2*FIELD_W-1:0] m_axis_tdata_o,   // out_x [15:0], out_y [31:16]
  output logic                 m_axis_tuser_o,   // inside_dead_zone [0]
  input  logic                 cfg_we_i,
  input  logic [DZ_W-1:0]      cfg_wdata_i
);

  localparam int RB = AXIS_BITS + FRAC_W;
  localparam int SW = 2 * AXIS_BITS;
  localparam int QB = AXIS_BITS;
  localparam int DW = RB + DZ_W + 1;
  localparam int DV = DW + 1;
  localparam int PW = DV + 1;
  localparam int AW = AXIS_BITS + RB;
  localparam int NW = AW + DZ_W + 2;
  localparam logic [RB-1:0] THR_RESET =
    RB'((longint'(DZ_RESET) << (AXIS_BITS - 1)) - longint'(DZ_RESET));
  localparam logic [DZ_W:0] COMP_RESET = DZ_ONE - (DZ_W+1)'(DZ_RESET);

  logic en;

  // ---------------- configuration ----------------
  logic [DZ_W-1:0] dz_q;
  logic [RB-1:0]   thr_q, thr_d;
  logic [DZ_W:0]   comp_q, comp_d;

  // Threshold dead_zone * full scale, and one minus dead_zone
  assign thr_d  = (RB'(dz_q) << (AXIS_BITS - 1)) - RB'(dz_q);
  assign comp_d = DZ_ONE - (DZ_W+1)'(dz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q   <= DZ_RESET;
      thr_q  <= THR_RESET;
      comp_q <= COMP_RESET;
    end else begin
      if (cfg_we_i) begin
        dz_q <= cfg_wdata_i;
      end
      thr_q  <= thr_d;
      comp_q <= comp_d;
    end
  end

  // ---------------- stage A: squares ----------------
  logic signed [AXIS_BITS-1:0] in_xs, in_ys;
  logic signed [SW-1:0]        in_xx, in_yy;
  logic                        a_v_q;
  logic [SW-1:0]               a_xx_q, a_yy_q;
  axes_t                       a_axes_q;
  logic [SW-1:0]               a_sum;

  assign in_xs = s_axis_tdata_i[AXIS_BITS-1:0];
  assign in_ys = s_axis_tdata_i[FIELD_W +: AXIS_BITS];
  assign in_xx = in_xs * in_xs;
  assign in_yy = in_ys * in_ys;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_xx_q     <= unsigned'(in_xx);
      a_yy_q     <= unsigned'(in_yy);
      a_axes_q.x <= FIELD_W'(in_xs);
      a_axes_q.y <= FIELD_W'(in_ys);
    end
  end

  assign a_sum = a_xx_q + a_yy_q;

  // ---------------- square root ----------------
  logic          sq_v;
  logic [RB-1:0] sq_r;
  axes_t         sq_axes;

  rsdz_sqrt #(
    .AXIS_BITS(AXIS_BITS)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, valid: a_v_q}),
    .sum_i  (a_sum),
    .axes_i (a_axes_q),
    .valid_o(sq_v),
    .root_o (sq_r),
    .axes_o (sq_axes)
  );

  // ---------------- stage M1: threshold, denominator ----------------
  logic                 m1_v_q;
  logic                 m1_inside_q, m1_zero_q;
  logic [RB-1:0]        m1_diff_q;
  logic [DW-1:0]        m1_den_q;
  logic [AXIS_BITS-1:0] m1_ax_q, m1_ay_q;
  axes_t                m1_axes_q;
  logic [AXIS_BITS-1:0] m1_xa, m1_ya, m1_ax_d, m1_ay_d;

  assign m1_xa   = sq_axes.x[AXIS_BITS-1:0];
  assign m1_ya   = sq_axes.y[AXIS_BITS-1:0];
  assign m1_ax_d = m1_xa[AXIS_BITS-1] ? (~m1_xa + 1'b1) : m1_xa;
  assign m1_ay_d = m1_ya[AXIS_BITS-1] ? (~m1_ya + 1'b1) : m1_ya;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_inside_q <= (sq_r < thr_q);
      m1_zero_q   <= (sq_r == '0);
      m1_diff_q   <= sq_r - thr_q;
      m1_den_q    <= DW'(sq_r) * DW'(comp_q);
      m1_ax_q     <= m1_ax_d;
      m1_ay_q     <= m1_ay_d;
      m1_axes_q   <= sq_axes;
    end
  end

  // ---------------- stage M2: clamp, numerators ----------------
  logic          m2_v_q;
  div_side_t     m2_side_q;
  logic [AW-1:0] m2_pax_q, m2_pay_q;
  logic [DW-1:0] m2_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_side_q.axes   <= m1_axes_q;
      m2_side_q.dz_hit <= m1_inside_q;
      m2_side_q.zero   <= m1_zero_q;
      m2_side_q.clamp  <= (DW'({m1_diff_q, {DZ_W{1'b0}}}) >= m1_den_q);
      m2_pax_q         <= AW'(m1_ax_q) * AW'(m1_diff_q);
      m2_pay_q         <= AW'(m1_ay_q) * AW'(m1_diff_q);
      m2_den_q         <= m1_den_q;
    end
  end

  // ---------------- stage M3: rounded dividends ----------------
  logic          m3_v_q;
  div_side_t     m3_side_q;
  logic [PW-1:0] m3_p0x_q, m3_p0y_q;
  logic [QB-1:0] m3_lx_q, m3_ly_q;
  logic [DV-1:0] m3_div_q;
  logic [NW-1:0] m3_nx, m3_ny;

  // dividend = 2*a*num + den with num = diff * 2^16
  assign m3_nx = NW'({m2_pax_q, {(DZ_W+1){1'b0}}}) + NW'(m2_den_q);
  assign m3_ny = NW'({m2_pay_q, {(DZ_W+1){1'b0}}}) + NW'(m2_den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (en) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_side_q <= m2_side_q;
      m3_p0x_q  <= PW'(m3_nx >> QB);
      m3_p0y_q  <= PW'(m3_ny >> QB);
      m3_lx_q   <= m3_nx[QB-1:0];
      m3_ly_q   <= m3_ny[QB-1:0];
      m3_div_q  <= {m2_den_q, 1'b0};
    end
  end

  // ---------------- divider ----------------
  logic          dv_v;
  logic [QB-1:0] dv_qx, dv_qy;
  div_side_t     dv_side;

  rsdz_div #(
    .AXIS_BITS(AXIS_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, valid: m3_v_q}),
    .p0x_i  (m3_p0x_q),
    .p0y_i  (m3_p0y_q),
    .lowx_i (m3_lx_q),
    .lowy_i (m3_ly_q),
    .div_i  (m3_div_q),
    .side_i (m3_side_q),
    .valid_o(dv_v),
    .qx_o   (dv_qx),
    .qy_o   (dv_qy),
    .side_o (dv_side)
  );

  // ---------------- result select ----------------
  logic [FIELD_W:0] fx_mag, fy_mag, fx_sgn, fy_sgn;
  res_t             res;

  assign fx_mag = (FIELD_W+1)'(dv_qx);
  assign fy_mag = (FIELD_W+1)'(dv_qy);
  assign fx_sgn = dv_side.axes.x[FIELD_W-1] ? (~fx_mag + 1'b1) : fx_mag;
  assign fy_sgn = dv_side.axes.y[FIELD_W-1] ? (~fy_mag + 1'b1) : fy_mag;

  // Zero inside the dead zone or at zero length, pass through when clamped, else signed quotients
  always_comb begin
    res.dz_hit = dv_side.dz_hit;
    if (dv_side.dz_hit || dv_side.zero) begin
      res.out_x = '0;
      res.out_y = '0;
    end else if (dv_side.clamp) begin
      res.out_x = dv_side.axes.x;
      res.out_y = dv_side.axes.y;
    end else begin
      res.out_x = fx_sgn[FIELD_W-1:0];
      res.out_y = fy_sgn[FIELD_W-1:0];
    end
  end

  // ---------------- output register and spare ----------------
  res_t out_res;

  rsdz_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dv_v),
    .in_data_i  (res),
    .en_o       (en),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (out_res)
  );

  assign s_axis_tready_o = en;
  assign m_axis_tdata_o  = {out_res.out_y, out_res.out_x};
  assign m_axis_tuser_o  = out_res.dz_hit;

endmodule
